// File: rtl/core/gre_pkg.sv
package gre_pkg;

    localparam int ROW_W  = 16;
    localparam int PIX_W  = 24;
    localparam int WORD_W = 32;
    localparam int IDX_W  = 4;
    localparam int CFG_W  = 24;
    localparam int CIDX_W = 3;

    localparam logic [CIDX_W-1:0] REG_FG_COLOR  = 3'd0;
    localparam logic [CIDX_W-1:0] REG_BG_COLOR  = 3'd1;
    localparam logic [CIDX_W-1:0] REG_WIDTH     = 3'd2;
    localparam logic [CIDX_W-1:0] REG_BIG_ENDIAN = 3'd3;

    localparam logic [PIX_W-1:0] FG_RESET    = 24'hFF_FFFF;
    localparam logic [PIX_W-1:0] BG_RESET    = 24'h00_0000;
    localparam logic [1:0]       WIDTH_RESET = 2'd1;

    typedef struct packed {
        logic             valid;
        logic [ROW_W-1:0] row;
        logic [IDX_W-1:0] idx;
        logic             last;
    } gre_req_t;

    typedef struct packed {
        logic                  valid;
        logic [3:0][PIX_W-1:0] pix;
        logic [1:0]            sel;
        logic [IDX_W-1:0]      idx;
        logic                  last;
    } gre_pix_t;

    function automatic logic [IDX_W-1:0] last_index(input logic [1:0] mode);
        logic [IDX_W-1:0] r;
        case (mode)
            2'd0:    r = 4'd2;
            2'd1:    r = 4'd5;
            2'd2:    r = 4'd8;
            default: r = 4'd11;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] group_of(input logic [IDX_W-1:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd1, 4'd2:   r = 2'd0;
            4'd3, 4'd4, 4'd5:   r = 2'd1;
            4'd6, 4'd7, 4'd8:   r = 2'd2;
            default:            r = 2'd3;
        endcase
        return r;
    endfunction

    function automatic logic [1:0] sel_of(input logic [IDX_W-1:0] idx);
        logic [1:0] r;
        case (idx)
            4'd0, 4'd3, 4'd6, 4'd9:   r = 2'd0;
            4'd1, 4'd4, 4'd7, 4'd10:  r = 2'd1;
            default:                  r = 2'd2;
        endcase
        return r;
    endfunction

endpackage

// File: rtl/core/gre_issue.sv
module gre_issue (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     advance,
    input  logic [1:0]               width_mode,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [gre_pkg::ROW_W-1:0] row_bits,
    output gre_pkg::gre_req_t        req
);
    import gre_pkg::*;

    logic             busy_reg, busy_next;
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [ROW_W-1:0] row_reg;
    logic             is_last;
    logic             take;

    assign is_last  = (idx_reg == last_index(width_mode));
    assign in_stall = !(advance && (!busy_reg || is_last));
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        if (advance)
        begin
            if (busy_reg && !is_last)
            begin
                idx_next = idx_reg + 4'd1;
            end
            else
            begin
                busy_next = take;
                idx_next  = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            row_reg <= row_bits;
        end
    end

    assign req.valid = busy_reg;
    assign req.row   = row_reg;
    assign req.idx   = idx_reg;
    assign req.last  = is_last;

endmodule

// File: rtl/core/gre_pixel.sv
module gre_pixel (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      advance,
    input  logic [gre_pkg::PIX_W-1:0] fg_color,
    input  logic [gre_pkg::PIX_W-1:0] bg_color,
    input  gre_pkg::gre_req_t         req,
    output gre_pkg::gre_pix_t         pix
);
    import gre_pkg::*;

    logic       valid_reg;
    gre_pix_t   pix_reg, pix_next;
    logic [3:0] nib;

    always_comb
    begin
        case (group_of(req.idx))
            2'd0:    nib = req.row[15:12];
            2'd1:    nib = req.row[11:8];
            2'd2:    nib = req.row[7:4];
            default: nib = req.row[3:0];
        endcase
        pix_next       = '0;
        pix_next.pix[0] = nib[3] ? fg_color : bg_color;
        pix_next.pix[1] = nib[2] ? fg_color : bg_color;
        pix_next.pix[2] = nib[1] ? fg_color : bg_color;
        pix_next.pix[3] = nib[0] ? fg_color : bg_color;
        pix_next.sel   = sel_of(req.idx);
        pix_next.idx   = req.idx;
        pix_next.last  = req.last;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= req.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pix_reg <= pix_next;
        end
    end

    always_comb
    begin
        pix       = pix_reg;
        pix.valid = valid_reg;
    end

endmodule

// File: rtl/core/gre_pack.sv
module gre_pack (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       big_endian,
    input  gre_pkg::gre_pix_t          pix,
    output logic                       advance,
    input  logic                       out_stall,
    output logic                       out_valid,
    output logic [gre_pkg::WORD_W-1:0] word,
    output logic [gre_pkg::IDX_W-1:0]  word_index,
    output logic                       last
);
    import gre_pkg::*;

    logic              valid_reg;
    logic [WORD_W-1:0] word_reg, word_next;
    logic [IDX_W-1:0]  idx_reg;
    logic              last_reg;
    logic [PIX_W-1:0]  a, b, c, d;

    assign a = pix.pix[0];
    assign b = pix.pix[1];
    assign c = pix.pix[2];
    assign d = pix.pix[3];

    assign advance = !valid_reg || !out_stall;

    always_comb
    begin
        case (pix.sel)
            2'd0:    word_next = big_endian ? {a, b[23:16]} : {b[7:0], a};
            2'd1:    word_next = big_endian ? {b[15:0], c[23:8]} : {c[15:0], b[23:8]};
            default: word_next = big_endian ? {c[7:0], d} : {d, c[23:16]};
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            valid_reg <= pix.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            word_reg <= word_next;
            idx_reg  <= pix.idx;
            last_reg <= pix.last;
        end
    end

    assign out_valid  = valid_reg;
    assign word       = word_reg;
    assign word_index = idx_reg;
    assign last       = last_reg;

endmodule

// File: rtl/core/glyph_row_expand_24bpp.sv
// Expands one glyph row into packed 24-bit pixels, three 32-bit words per four
// pixels, one word per cycle while the output is not stalled. A row has 3, 6, 9
// or 12 words (set by width_mode), which the word issuer steps through; the
// next row is taken in the cycle its last word is issued, so rows follow with
// no gap. The first word of a row passes the issuer, pixel select and pack
// registers in that order. A stall on a waiting output word freezes all stages.
// Write the configuration registers only while no row is in flight.
module glyph_row_expand_24bpp (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [gre_pkg::CIDX_W-1:0]  cfg_index,
    input  logic [gre_pkg::CFG_W-1:0]   cfg_data,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic [gre_pkg::ROW_W-1:0]   row_bits,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [gre_pkg::WORD_W-1:0]  word,
    output logic [gre_pkg::IDX_W-1:0]   word_index,
    output logic                        last
);
    import gre_pkg::*;

    logic [PIX_W-1:0] fg_color_reg;
    logic [PIX_W-1:0] bg_color_reg;
    logic [1:0]       width_mode_reg;
    logic             big_endian_reg;
    logic             advance;
    gre_req_t         req;
    gre_pix_t         pix;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fg_color_reg   <= FG_RESET;
            bg_color_reg   <= BG_RESET;
            width_mode_reg <= WIDTH_RESET;
            big_endian_reg <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_FG_COLOR:   fg_color_reg   <= cfg_data;
                REG_BG_COLOR:   bg_color_reg   <= cfg_data;
                REG_WIDTH:      width_mode_reg <= cfg_data[1:0];
                REG_BIG_ENDIAN: big_endian_reg <= cfg_data[0];
                default:        ;
            endcase
        end
    end

    gre_issue u_issue (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .width_mode (width_mode_reg),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .row_bits   (row_bits),
        .req        (req)
    );

    gre_pixel u_pixel (
        .clk      (clk),
        .rst_n    (rst_n),
        .advance  (advance),
        .fg_color (fg_color_reg),
        .bg_color (bg_color_reg),
        .req      (req),
        .pix      (pix)
    );

    gre_pack u_pack (
        .clk        (clk),
        .rst_n      (rst_n),
        .big_endian (big_endian_reg),
        .pix        (pix),
        .advance    (advance),
        .out_stall  (out_stall),
        .out_valid  (out_valid),
        .word       (word),
        .word_index (word_index),
        .last       (last)
    );

endmodule

// File: rtl/core/gre_checker.sv
module gre_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_stall,
    input logic [gre_pkg::IDX_W-1:0]   word_index,
    input logic                        last
);

    // hold a stalled item
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(word_index) && $stable(last))
        else $error("stalled output item changed");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> word_index <= 4'd11)
        else $error("word index out of range");

    a_last_pos: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && last |-> (word_index == 4'd2 || word_index == 4'd5 ||
                               word_index == 4'd8 || word_index == 4'd11))
        else $error("last on a word that does not end a group");

    a_idx_step: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall && !last |=>
            out_valid && word_index == 4'($past(word_index) + 4'd1))
        else $error("words of a row not contiguous");

endmodule

bind glyph_row_expand_24bpp gre_checker u_gre_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .word_index (word_index),
    .last       (last)
);
